FILE: src/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// shared widths, codes and the job record passed from front to back
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam int CHAR_W    = 8;
    localparam int POS_W     = 4;
    localparam int MANT_W    = 27;
    localparam int EXP_W     = 7;
    localparam int VALUE_W   = 64;
    localparam int OFFSET_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  expo;
        logic              value_neg;
        logic              exp_neg;
        logic              marker_seen;
    } t_job;

endpackage

FILE: src/mrp_front.sv
// ----------------------------------------------------------------------------
// mrp_front
// character front end: digit mapping, positional accumulation, job hand-off
// ----------------------------------------------------------------------------
module mrp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mrp_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    output logic                        o_push_valid,
    input  logic                        i_push_ready,
    output mrp_pkg::t_job               o_push_job
);

    localparam logic [mrp_pkg::POS_W-1:0]  POS_LAST   = 4'd14;
    localparam logic [mrp_pkg::POS_W-1:0]  POS_SIGN   = 4'd0;
    localparam logic [mrp_pkg::POS_W-1:0]  POS_MARKER = 4'd11;
    localparam logic [mrp_pkg::POS_W-1:0]  POS_ESIGN  = 4'd12;
    localparam logic [mrp_pkg::POS_W-1:0]  POS_ETENS  = 4'd13;
    localparam logic [mrp_pkg::POS_W-1:0]  POS_EUNITS = 4'd14;
    localparam logic [mrp_pkg::CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [mrp_pkg::CHAR_W-1:0] CH_E       = 8'h45;
    localparam logic [mrp_pkg::CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [mrp_pkg::CHAR_W-1:0] CH_NINE    = 8'h39;

    function automatic logic [23:0] mant_weight(input logic [mrp_pkg::POS_W-1:0] pos);
        logic [23:0] w;
        case (pos)
            4'd1:    w = 24'd10000000;
            4'd3:    w = 24'd1000000;
            4'd4:    w = 24'd100000;
            4'd5:    w = 24'd10000;
            4'd6:    w = 24'd1000;
            4'd7:    w = 24'd100;
            4'd8:    w = 24'd10;
            4'd9:    w = 24'd1;
            default: w = 24'd0;
        endcase
        return w;
    endfunction

    // missing positions from pos on, each counted as digit ten
    function automatic logic [mrp_pkg::MANT_W-1:0] mant_fill(
        input logic [mrp_pkg::POS_W-1:0] pos);
        logic [mrp_pkg::MANT_W-1:0] f;
        case (pos)
            4'd0, 4'd1: f = 27'd111111110;
            4'd2, 4'd3: f = 27'd11111110;
            4'd4:       f = 27'd1111110;
            4'd5:       f = 27'd111110;
            4'd6:       f = 27'd11110;
            4'd7:       f = 27'd1110;
            4'd8:       f = 27'd110;
            4'd9:       f = 27'd10;
            default:    f = 27'd0;
        endcase
        return f;
    endfunction

    function automatic logic [mrp_pkg::EXP_W-1:0] exp_fill(
        input logic [mrp_pkg::POS_W-1:0] pos);
        logic [mrp_pkg::EXP_W-1:0] f;
        case (pos)
            4'd14:   f = 7'd10;
            4'd15:   f = 7'd0;
            default: f = 7'd110;
        endcase
        return f;
    endfunction

    logic [mrp_pkg::POS_W-1:0]  r_pos,    n_pos;
    logic [mrp_pkg::MANT_W-1:0] r_mant,   n_mant;
    logic [mrp_pkg::EXP_W-1:0]  r_exp,    n_exp;
    logic                       r_vneg,   n_vneg;
    logic                       r_eseen,  n_eseen;
    logic                       r_eneg,   n_eneg;

    logic                       w_active;
    logic [3:0]                 w_digit;
    logic [mrp_pkg::MANT_W-1:0] w_mant_term;
    logic [mrp_pkg::EXP_W-1:0]  w_exp_term;
    logic [mrp_pkg::POS_W-1:0]  w_pos_adv;
    logic [mrp_pkg::MANT_W-1:0] w_mant_upd;
    logic [mrp_pkg::EXP_W-1:0]  w_exp_upd;
    logic                       w_vneg_upd;
    logic                       w_eseen_upd;
    logic                       w_eneg_upd;
    logic                       w_accept;

    assign o_ready  = i_push_ready;
    assign w_accept = i_valid && i_push_ready;
    assign w_active = (r_pos <= POS_LAST);
    assign w_digit  = (i_char >= CH_ZERO && i_char <= CH_NINE) ? i_char[3:0] : 4'd10;

    always_comb begin
        w_mant_term = '0;
        w_exp_term  = '0;
        if (w_active) begin
            w_mant_term = mrp_pkg::MANT_W'(w_digit) * mrp_pkg::MANT_W'(mant_weight(r_pos));
            if (r_pos == POS_ETENS) begin
                w_exp_term = mrp_pkg::EXP_W'(w_digit) * 7'd10;
            end else if (r_pos == POS_EUNITS) begin
                w_exp_term = mrp_pkg::EXP_W'(w_digit);
            end
        end
        w_pos_adv   = w_active ? r_pos + 4'd1 : r_pos;
        w_mant_upd  = r_mant + w_mant_term;
        w_exp_upd   = r_exp + w_exp_term;
        w_vneg_upd  = (w_active && r_pos == POS_SIGN)   ? (i_char == CH_MINUS) : r_vneg;
        w_eseen_upd = (w_active && r_pos == POS_MARKER) ? (i_char == CH_E)     : r_eseen;
        w_eneg_upd  = (w_active && r_pos == POS_ESIGN)  ? (i_char == CH_MINUS) : r_eneg;
    end

    assign o_push_valid            = i_valid && i_last;
    assign o_push_job.mant         = w_mant_upd + mant_fill(w_pos_adv);
    assign o_push_job.expo         = w_exp_upd + exp_fill(w_pos_adv);
    assign o_push_job.value_neg    = w_vneg_upd;
    assign o_push_job.exp_neg      = w_eneg_upd;
    assign o_push_job.marker_seen  = w_eseen_upd;

    always_comb begin
        n_pos   = r_pos;
        n_mant  = r_mant;
        n_exp   = r_exp;
        n_vneg  = r_vneg;
        n_eseen = r_eseen;
        n_eneg  = r_eneg;
        if (w_accept) begin
            if (i_last) begin
                n_pos   = '0;
                n_mant  = '0;
                n_exp   = '0;
                n_vneg  = 1'b0;
                n_eseen = 1'b0;
                n_eneg  = 1'b0;
            end else begin
                n_pos   = w_pos_adv;
                n_mant  = w_mant_upd;
                n_exp   = w_exp_upd;
                n_vneg  = w_vneg_upd;
                n_eseen = w_eseen_upd;
                n_eneg  = w_eneg_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_mant  <= '0;
            r_exp   <= '0;
            r_vneg  <= 1'b0;
            r_eseen <= 1'b0;
            r_eneg  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_mant  <= n_mant;
            r_exp   <= n_exp;
            r_vneg  <= n_vneg;
            r_eseen <= n_eseen;
            r_eneg  <= n_eneg;
        end
    end

endmodule

FILE: src/mrp_queue.sv
// ----------------------------------------------------------------------------
// mrp_queue
// short job queue between front end and arithmetic back end
// ----------------------------------------------------------------------------
module mrp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  mrp_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output mrp_pkg::t_job o_pop_job
);

    mrp_pkg::t_job                  r_mem [mrp_pkg::QUEUE_DEPTH];
    logic [mrp_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [mrp_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [mrp_pkg::QCNT_W-1:0]     r_count,  n_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_push_ready = (r_count != mrp_pkg::QCNT_W'(mrp_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    function automatic logic [mrp_pkg::QPTR_W-1:0] ptr_inc(
        input logic [mrp_pkg::QPTR_W-1:0] p);
        logic [mrp_pkg::QPTR_W-1:0] r;
        if (p == mrp_pkg::QPTR_W'(mrp_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        n_wr_ptr = w_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: src/mrp_back.sv
// ----------------------------------------------------------------------------
// mrp_back
// reading arithmetic: exponent scaling, current scaling, sign, offset, clamp
// ----------------------------------------------------------------------------
module mrp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  mrp_pkg::t_job                 i_pop_job,
    input  logic                          i_cur_mode,
    input  logic [mrp_pkg::OFFSET_W-1:0]  i_cur_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mrp_pkg::VALUE_W-1:0]   o_out_value,
    output logic                          o_out_ovf
);

    localparam int SUM_W = mrp_pkg::VALUE_W + 2;
    localparam int PP_W  = 42;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ITER = 3'd1;
    localparam logic [2:0] ST_SCL1 = 3'd2;
    localparam logic [2:0] ST_SCL2 = 3'd3;
    localparam logic [2:0] ST_SGN  = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;

    localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
    localparam logic [9:0]  CUR_SCALE   = 10'd750;
    localparam logic [mrp_pkg::VALUE_W-1:0] MAG_MAX = '1;
    localparam logic [mrp_pkg::VALUE_W-1:0] INT_MAX = {1'b0, {(mrp_pkg::VALUE_W-1){1'b1}}};
    localparam logic [mrp_pkg::VALUE_W-1:0] INT_MIN = {1'b1, {(mrp_pkg::VALUE_W-1){1'b0}}};

    logic [2:0]                   r_state, n_state;
    logic [mrp_pkg::VALUE_W-1:0]  r_mag,   n_mag;
    logic [mrp_pkg::EXP_W-1:0]    r_cnt,   n_cnt;
    logic                         r_neg,   n_neg;
    logic                         r_eneg,  n_eneg;
    logic [PP_W-1:0]              r_pa,    n_pa;
    logic [PP_W-1:0]              r_pb,    n_pb;
    logic signed [SUM_W-1:0]      r_sv,    n_sv;
    logic                         r_out_valid, n_out_valid;
    logic [mrp_pkg::VALUE_W-1:0]  r_out_value, n_out_value;
    logic                         r_out_ovf,   n_out_ovf;

    logic [63:0]                  w_prod;
    logic [mrp_pkg::VALUE_W-1:0]  w_quot;
    logic [mrp_pkg::VALUE_W+3:0]  w_x10;
    logic [mrp_pkg::VALUE_W+9:0]  w_scaled;
    logic signed [SUM_W-1:0]      w_sum;
    logic [mrp_pkg::OFFSET_W-1:0] w_off;
    logic                         w_out_free;

    // divide path only ever sees the 27-bit mantissa or less
    assign w_prod   = 64'(r_mag[31:0]) * 64'(DIV10_RECIP);
    assign w_quot   = mrp_pkg::VALUE_W'(w_prod[63:35]);
    assign w_x10    = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0};
    assign w_scaled = {r_pb, 32'd0} + {32'd0, r_pa};
    assign w_off    = i_cur_mode ? i_cur_offset : '0;
    assign w_sum    = r_sv + {{(SUM_W-mrp_pkg::OFFSET_W){w_off[mrp_pkg::OFFSET_W-1]}}, w_off};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_pop_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_ovf   = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_eneg      = r_eneg;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_sv        = r_sv;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    n_mag   = i_pop_job.marker_seen ?
                              mrp_pkg::VALUE_W'(i_pop_job.mant) : '0;
                    n_cnt   = i_pop_job.marker_seen ? i_pop_job.expo : '0;
                    n_neg   = i_pop_job.marker_seen && i_pop_job.value_neg;
                    n_eneg  = i_pop_job.exp_neg;
                    n_state = ST_ITER;
                end
            end
            ST_ITER: begin
                if (r_cnt == '0 || r_mag == '0) begin
                    n_state = i_cur_mode ? ST_SCL1 : ST_SGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_eneg) begin
                        n_mag = w_quot;
                    end else if (w_x10[mrp_pkg::VALUE_W+3:mrp_pkg::VALUE_W] != '0) begin
                        n_mag = MAG_MAX;
                    end else begin
                        n_mag = w_x10[mrp_pkg::VALUE_W-1:0];
                    end
                end
            end
            ST_SCL1: begin
                n_pa    = PP_W'(r_mag[31:0]) * PP_W'(CUR_SCALE);
                n_pb    = PP_W'(r_mag[63:32]) * PP_W'(CUR_SCALE);
                n_state = ST_SCL2;
            end
            ST_SCL2: begin
                n_mag   = (w_scaled[mrp_pkg::VALUE_W+9:mrp_pkg::VALUE_W] != '0) ?
                          MAG_MAX : w_scaled[mrp_pkg::VALUE_W-1:0];
                n_state = ST_SGN;
            end
            ST_SGN: begin
                n_sv    = r_neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_sum[SUM_W-1:SUM_W-3] == 3'b000 ||
                        w_sum[SUM_W-1:SUM_W-3] == 3'b111) begin
                        n_out_value = w_sum[mrp_pkg::VALUE_W-1:0];
                        n_out_ovf   = 1'b0;
                    end else begin
                        n_out_value = w_sum[SUM_W-1] ? INT_MIN : INT_MAX;
                        n_out_ovf   = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_cnt       <= n_cnt;
        r_neg       <= n_neg;
        r_eneg      <= n_eneg;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
        r_sv        <= n_sv;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: src/meter_reading_parser.sv
// result path: the last character of a reading pushes its job into the queue; the back end
//   then steps the decimal exponent e (0 to 110), in current mode scales the value, applies
//   the sign and, in current mode, the offset; the exponent loop stops early once the value reaches zero
// throughput: one character per cycle while the two-entry job queue has room; the
//   arithmetic unit takes one reading at a time, one exponent step per cycle
// reset: synchronous, active low; clears the partial reading, the queue, the output
//   valid flag and both configuration registers
// ----------------------------------------------------------------------------
// meter_reading_parser
// ascii multimeter reading to saturated signed 64-bit integer
// ----------------------------------------------------------------------------
module meter_reading_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // char_in[7:0]
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [63:0]                      m_axis_tdata,  // reading_value[63:0]
    output logic                             m_axis_tuser,  // overflow
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);

    logic                            r_cur_mode,   n_cur_mode;
    logic [mrp_pkg::OFFSET_W-1:0]    r_cur_offset, n_cur_offset;

    logic                            w_push_valid;
    logic                            w_push_ready;
    mrp_pkg::t_job                   w_push_job;
    logic                            w_pop_valid;
    logic                            w_pop_ready;
    mrp_pkg::t_job                   w_pop_job;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cur_mode   = r_cur_mode;
        n_cur_offset = r_cur_offset;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                mrp_pkg::CFG_MODE:   n_cur_mode   = i_cfg_data[0];
                mrp_pkg::CFG_OFFSET: n_cur_offset = i_cfg_data;
                default: begin
                    n_cur_mode = r_cur_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mode   <= 1'b0;
            r_cur_offset <= '0;
        end else begin
            r_cur_mode   <= n_cur_mode;
            r_cur_offset <= n_cur_offset;
        end
    end

    mrp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_char       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    mrp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    mrp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_pop_valid),
        .o_pop_ready  (w_pop_ready),
        .i_pop_job    (w_pop_job),
        .i_cur_mode   (r_cur_mode),
        .i_cur_offset (r_cur_offset),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_value  (m_axis_tdata),
        .o_out_ovf    (m_axis_tuser)
    );

endmodule
